// ----- design/lfuct_pkg.sv -----
// Shared constants and types for the LFU cache table.
// Used by lfuct_scan and lfu_cache_table; depends on nothing else.
package lfuct_pkg;

  // Store geometry
  localparam int ENTRIES     = 16;
  localparam int COUNT_WIDTH = 16;
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int IDX_W       = $clog2(ENTRIES);
  localparam int OCC_W       = $clog2(ENTRIES + 1);

  // Capacity register
  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
  localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  // Operation codes
  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_PUT = 1'b1;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);

  // What one pass over the entries finds
  typedef struct packed {
    logic                   found;
    logic [IDX_W-1:0]       hit_slot;
    logic [IDX_W-1:0]       hit_rank;
    logic [COUNT_WIDTH-1:0] hit_count;
    logic                   has_victim;
    logic [IDX_W-1:0]       victim;
    logic [IDX_W-1:0]       victim_rank;
    logic [KEY_W-1:0]       victim_key;
    logic [IDX_W-1:0]       free_slot;
    logic [OCC_W-1:0]       occupancy;
  } scan_res_t;

endpackage

// ----- design/lfuct_scan.sv -----
// Entry scanner: steps through the table one entry a cycle, matching the key
// and tracking the eviction victim, free slot and occupancy. Uses lfuct_pkg.
module lfuct_scan (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [lfuct_pkg::KEY_W-1:0]        search_key,
  input  logic                               entry_valid,
  input  logic [lfuct_pkg::KEY_W-1:0]        entry_key,
  input  logic [lfuct_pkg::COUNT_WIDTH-1:0]  entry_count,
  input  logic [lfuct_pkg::IDX_W-1:0]        entry_rank,
  output logic [lfuct_pkg::IDX_W-1:0]        idx,
  output logic                               last,
  output lfuct_pkg::scan_res_t               res
);
  import lfuct_pkg::*;

  logic                   busy;
  logic                   seen_free;
  logic [COUNT_WIDTH-1:0] victim_count;
  logic                   take_victim;
  logic                   is_match;

  assign last = busy && (idx == IDX_W'(ENTRIES - 1));

  // Lowest count wins; on equal counts the older (higher rank) entry wins
  assign take_victim = entry_valid &&
                       (!res.has_victim || (entry_count < victim_count) ||
                        ((entry_count == victim_count) && (entry_rank > res.victim_rank)));
  assign is_match = entry_valid && (entry_key == search_key);

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (busy) begin
      idx <= idx + IDX_W'(1);
      if (last) begin
        busy <= 1'b0;
      end
    end
  end

  // Trackers, cleared at the start of each pass
  always_ff @(posedge clk) begin
    if (rst || start) begin
      res.found      <= 1'b0;
      res.has_victim <= 1'b0;
      res.occupancy  <= '0;
      seen_free      <= 1'b0;
    end else if (busy) begin
      res.occupancy <= res.occupancy + {{(OCC_W-1){1'b0}}, entry_valid};
      if (is_match) begin
        res.found     <= 1'b1;
        res.hit_slot  <= idx;
        res.hit_rank  <= entry_rank;
        res.hit_count <= entry_count;
      end
      if (take_victim) begin
        res.has_victim  <= 1'b1;
        res.victim      <= idx;
        res.victim_rank <= entry_rank;
        res.victim_key  <= entry_key;
        victim_count    <= entry_count;
      end
      if (!entry_valid && !seen_free) begin
        seen_free     <= 1'b1;
        res.free_slot <= idx;
      end
    end
  end

endmodule

// ----- design/lfu_cache_table.sv -----
// LFU cache table top level: entry storage, sequencer and result register.
// Depends on lfuct_pkg and lfuct_scan.
//
// Usage:
//   Request channel (req_valid/req_stall) carries kind, lookup_key and
//   write_value; kind selects get or put. Response channel (rsp_valid/
//   rsp_stall) returns hit, read_value, evicted and evicted_key, one item
//   per request, in order.
//   Sequence: a request is taken, then the scanner walks all 16 entries, one
//   a cycle, through a single key/count/rank compare unit, then the commit
//   state updates the table and loads the response register. The next
//   request is taken only once that item's commit is done; the
//   response is valid in the cycle after commit.
//   req_stall is high while an item is in progress. The response register
//   decouples the sides: a new request is taken while a response waits, but
//   the commit waits if the previous response has not been taken.
//   Configuration: cfg_valid/cfg_ready write capacity_in_use (always ready).
//   Reset (rst, synchronous) empties the table, sets capacity to 16 and
//   clears both valids. No clearing pass is needed.
module lfu_cache_table (
  input  logic                             clk,
  input  logic                             rst,
  // Configuration
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lfuct_pkg::CAP_W-1:0]      capacity_in_use,
  // Requests
  input  logic                             req_valid,
  output logic                             req_stall,
  input  logic                             kind,
  input  logic signed [lfuct_pkg::KEY_W-1:0] lookup_key,
  input  logic signed [lfuct_pkg::VAL_W-1:0] write_value,
  // Responses
  output logic                             rsp_valid,
  input  logic                             rsp_stall,
  output logic                             hit,
  output logic signed [lfuct_pkg::VAL_W-1:0] read_value,
  output logic                             evicted,
  output logic signed [lfuct_pkg::KEY_W-1:0] evicted_key
);
  import lfuct_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  logic [CAP_W-1:0] capacity;

  // Latched request
  logic             op;
  logic [KEY_W-1:0] key;
  logic [VAL_W-1:0] value;

  // Table storage
  logic                   entry_valid [ENTRIES];
  logic                   entry_valid_next [ENTRIES];
  logic [IDX_W-1:0]       rank [ENTRIES];
  logic [IDX_W-1:0]       rank_next [ENTRIES];
  logic [KEY_W-1:0]       entry_key [ENTRIES];
  logic [VAL_W-1:0]       entry_value [ENTRIES];
  logic [COUNT_WIDTH-1:0] use_count [ENTRIES];

  // Scanner
  logic             accept;
  logic [IDX_W-1:0] scan_idx;
  logic             scan_last;
  scan_res_t        res;

  // Commit decisions
  logic             commit;
  logic             do_touch;
  logic             do_insert;
  logic             do_evict;
  logic             full;
  logic [CMP_W-1:0] occ_ext;
  logic [CMP_W-1:0] cap_ext;
  logic [IDX_W-1:0] slot;
  logic [COUNT_WIDTH-1:0] touch_count;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign commit    = (state == ST_COMMIT) && !(rsp_valid && rsp_stall);

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= capacity_in_use;
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept) state_next = ST_SCAN;
      ST_SCAN:   if (scan_last) state_next = ST_COMMIT;
      ST_COMMIT: if (commit) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      op    <= kind;
      key   <= lookup_key;
      value <= write_value;
    end
  end

  lfuct_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .start       (accept),
    .search_key  (key),
    .entry_valid (entry_valid[scan_idx]),
    .entry_key   (entry_key[scan_idx]),
    .entry_count (use_count[scan_idx]),
    .entry_rank  (rank[scan_idx]),
    .idx         (scan_idx),
    .last        (scan_last),
    .res         (res)
  );

  // What the commit does
  assign occ_ext   = CMP_W'(res.occupancy);
  assign cap_ext   = CMP_W'(capacity);
  assign full      = (occ_ext >= cap_ext) || (res.occupancy == OCC_W'(ENTRIES));
  assign do_touch  = res.found && ((op == KIND_GET) || (capacity != '0));
  assign do_insert = (op == KIND_PUT) && (capacity != '0) && !res.found;
  assign do_evict  = do_insert && full && res.has_victim;
  assign slot      = do_evict ? res.victim : res.free_slot;
  assign touch_count = (res.hit_count == COUNT_MAX) ? res.hit_count
                                                    : res.hit_count + COUNT_ONE;

  // Recency ranks and valid bits, updated per entry
  always_comb begin
    for (int j = 0; j < ENTRIES; j++) begin
      entry_valid_next[j] = entry_valid[j];
      rank_next[j]        = rank[j];
      if (do_touch) begin
        if (IDX_W'(j) == res.hit_slot) begin
          rank_next[j] = '0;
        end else if (entry_valid[j] && (rank[j] < res.hit_rank)) begin
          rank_next[j] = rank[j] + IDX_W'(1);
        end
      end else if (do_insert) begin
        if (IDX_W'(j) == slot) begin
          entry_valid_next[j] = 1'b1;
          rank_next[j]        = '0;
        end else if (entry_valid[j] && !(do_evict && (rank[j] > res.victim_rank))) begin
          rank_next[j] = rank[j] + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < ENTRIES; j++) begin
      if (rst) begin
        entry_valid[j] <= 1'b0;
      end else if (commit) begin
        entry_valid[j] <= entry_valid_next[j];
      end
      if (commit) begin
        rank[j] <= rank_next[j];
      end
    end
  end

  // Key, value and count storage
  always_ff @(posedge clk) begin
    if (commit) begin
      if (do_insert) begin
        entry_key[slot]   <= key;
        entry_value[slot] <= value;
        use_count[slot]   <= COUNT_ONE;
      end else if (do_touch) begin
        use_count[res.hit_slot] <= touch_count;
        if (op == KIND_PUT) begin
          entry_value[res.hit_slot] <= value;
        end
      end
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (commit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      hit         <= res.found;
      read_value  <= (res.found && (op == KIND_GET)) ? entry_value[res.hit_slot] : '0;
      evicted     <= do_evict;
      evicted_key <= do_evict ? res.victim_key : '0;
    end
  end

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for lfu_cache_table: an LFU store with LRU tie-breaking.
// Drives requests and the capacity register, predicts every response and checks it.
// Depends on lfuct_pkg and the lfu_cache_table RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lfuct_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int SEGMENTS     = 12;
  localparam int SEGMENT_SIZE = 112;

  typedef struct packed {
    logic             kind;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] wdata;
  } cache_req_t;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] rdata;
    logic             evicted;
    logic [KEY_W-1:0] ekey;
  } cache_rsp_t;

  // Clock, reset and block ports
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CAP_W-1:0]        capacity_in_use = CAP_RESET;
  logic                    req_valid = 1'b0;
  logic                    req_stall;
  logic                    kind = KIND_GET;
  logic signed [KEY_W-1:0] lookup_key = '0;
  logic signed [VAL_W-1:0] write_value = '0;
  logic                    rsp_valid;
  logic                    rsp_stall = 1'b0;
  logic                    hit;
  logic signed [VAL_W-1:0] read_value;
  logic                    evicted;
  logic signed [KEY_W-1:0] evicted_key;

  // Testbench state
  cache_req_t       request_backlog[$];
  cache_rsp_t       expected_responses[$];
  logic             req_taken = 1'b0;
  int               send_idle_pct = 0;
  int               recv_stall_pct = 0;
  int               mismatches = 0;
  int               cycle_count = 0;
  logic [CAP_W-1:0] seg_caps [SEGMENTS];

  // Shadow copy of the table
  logic                   sh_valid [ENTRIES];
  logic [KEY_W-1:0]       sh_key   [ENTRIES];
  logic [VAL_W-1:0]       sh_value [ENTRIES];
  logic [COUNT_WIDTH-1:0] sh_count [ENTRIES];
  longint                 sh_stamp [ENTRIES];
  longint                 use_clock = 0;
  logic [CAP_W-1:0]       cap_now = CAP_RESET;

  lfu_cache_table dut (
    .clk, .rst,
    .cfg_valid, .cfg_ready, .capacity_in_use,
    .req_valid, .req_stall, .kind, .lookup_key, .write_value,
    .rsp_valid, .rsp_stall, .hit, .read_value, .evicted, .evicted_key
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // One use of a slot: bump the count (saturating) and make it most recent
  function automatic void note_use(int s);
    if (sh_count[s] != COUNT_MAX) sh_count[s] = sh_count[s] + 1'b1;
    use_clock++;
    sh_stamp[s] = use_clock;
  endfunction

  // Apply one request to the shadow table and return the response it causes
  function automatic cache_rsp_t predict_access(cache_req_t rq);
    cache_rsp_t r;
    int slot, victim, live, limit;
    r = '0;
    slot = -1;
    victim = -1;
    live = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (sh_valid[i] && sh_key[i] == rq.key) slot = i;
      if (sh_valid[i]) live++;
    end
    r.hit = (slot >= 0);
    if (rq.kind == KIND_GET) begin
      if (slot >= 0) begin
        r.rdata = sh_value[slot];
        note_use(slot);
      end
      return r;
    end
    // puts are dropped entirely at capacity zero
    if (cap_now == 0) return r;
    if (slot >= 0) begin
      sh_value[slot] = rq.wdata;
      note_use(slot);
      return r;
    end
    limit = (cap_now > ENTRIES) ? ENTRIES : int'(cap_now);
    if (live >= limit) begin
      // lowest count goes; among equal counts the least recently used
      for (int i = 0; i < ENTRIES; i++)
        if (sh_valid[i] && (victim < 0 || sh_count[i] < sh_count[victim] ||
            (sh_count[i] == sh_count[victim] && sh_stamp[i] < sh_stamp[victim])))
          victim = i;
      sh_valid[victim] = 1'b0;
      r.evicted = 1'b1;
      r.ekey = sh_key[victim];
    end
    for (int i = 0; i < ENTRIES; i++)
      if (!sh_valid[i] && slot < 0) slot = i;
    sh_valid[slot] = 1'b1;
    sh_key[slot]   = rq.key;
    sh_value[slot] = rq.wdata;
    sh_count[slot] = COUNT_ONE;
    use_clock++;
    sh_stamp[slot] = use_clock;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endfunction

  // Driver: new item after acceptance or when idle, random gaps and stalls
  always @(negedge clk) begin : drive_requests
    cache_req_t nxt;
    if (!req_valid || req_taken) begin
      if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = request_backlog.pop_front();
        req_valid   <= 1'b1;
        kind        <= nxt.kind;
        lookup_key  <= nxt.key;
        write_value <= nxt.wdata;
      end else begin
        req_valid <= 1'b0;
      end
    end
    rsp_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Monitor: check responses first, then predict for the item just taken
  always @(posedge clk) begin : watch_channels
    cache_rsp_t want;
    cache_req_t rq;
    req_taken <= req_valid && !req_stall;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_responses.size() == 0) begin
        $error("response with no request outstanding");
        mismatches++;
      end else begin
        want = expected_responses.pop_front();
        check_field("hit", 32'(want.hit), 32'(hit));
        check_field("read_value", want.rdata, read_value);
        check_field("evicted", 32'(want.evicted), 32'(evicted));
        check_field("evicted_key", want.ekey, evicted_key);
      end
    end
    if (!rst && req_valid && !req_stall) begin
      rq = {kind, lookup_key, write_value};
      expected_responses.push_back(predict_access(rq));
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_request(logic k, logic [31:0] key, logic [31:0] wdata);
    cache_req_t rq;
    rq.kind  = k;
    rq.key   = key;
    rq.wdata = wdata;
    request_backlog.push_back(rq);
  endtask

  // Block is idle once nothing is queued, presented or outstanding; checked at
  // the rising edge, where the driver's outputs have settled
  task automatic wait_idle();
    while (request_backlog.size() != 0 || req_valid || expected_responses.size() != 0)
      @(posedge clk);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] v);
    @(negedge clk);
    cfg_valid       <= 1'b1;
    capacity_in_use <= v;
    do @(posedge clk); while (!cfg_ready);
    cap_now = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [31:0] key_pool[$];
    int          psize;
    logic [31:0] k;
    for (int i = 0; i < ENTRIES; i++) begin
      sh_valid[i] = 1'b0;
      sh_key[i]   = '0;
      sh_value[i] = '0;
      sh_count[i] = '0;
      sh_stamp[i] = 0;
    end
    seg_caps = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd2, 5'd17, 5'd5, 5'd16, 5'd8, 5'd3, 5'd20, 5'd12};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty miss, extreme keys and values, update, get ignores write data
    send_idle_pct  = 16;
    recv_stall_pct = 61;
    queue_request(KIND_GET, 32'h0000_0000, 32'hDEAD_BEEF);
    queue_request(KIND_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_request(KIND_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_request(KIND_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_request(KIND_GET, 32'h7FFF_FFFF, 32'h1234_5678);
    queue_request(KIND_PUT, 32'h7FFF_FFFF, 32'h0000_0000);
    queue_request(KIND_GET, 32'h8000_0000, 32'hFFFF_FFFF);
    queue_request(KIND_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_request(KIND_GET, 32'h7FFF_FFFF, 32'h5555_5555);
    wait_idle();

    // Capacity zero: puts change nothing, gets still read
    set_capacity(5'd0);
    queue_request(KIND_PUT, 32'h1234_5678, 32'h0000_0001);
    queue_request(KIND_PUT, 32'h0000_0000, 32'h0000_0005);
    queue_request(KIND_GET, 32'h0000_0000, 32'h0000_0000);
    queue_request(KIND_GET, 32'h1234_5678, 32'h0000_0000);
    wait_idle();

    // Capacity below occupancy: each insert evicts exactly one, count ties go LRU
    set_capacity(5'd2);
    queue_request(KIND_PUT, 32'h5555_5555, 32'hAAAA_AAAA);
    queue_request(KIND_PUT, 32'h0AAA_AAAA, 32'h0000_0002);
    queue_request(KIND_GET, 32'h5555_5555, 32'h0000_0000);
    queue_request(KIND_PUT, 32'hFFFF_FFFE, 32'h0000_0003);

    // Random segments, each with its own capacity and key pool
    for (int s = 0; s < SEGMENTS; s++) begin
      wait_idle();
      if (s == 4) begin
        send_idle_pct  = 61;
        recv_stall_pct = 16;
      end else if (s == 8) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      set_capacity(seg_caps[s]);
      psize = ((seg_caps[s] > ENTRIES) ? ENTRIES : int'(seg_caps[s])) + 4;
      key_pool.delete();
      for (int i = 0; i < psize; i++) key_pool.push_back(pick_word());
      for (int n = 0; n < SEGMENT_SIZE; n++) begin
        if ($urandom_range(99) < 80) k = key_pool[$urandom_range(psize - 1)];
        else k = $urandom;
        queue_request(($urandom_range(99) < 50) ? KIND_PUT : KIND_GET, k, pick_word());
      end
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
